// ----- sv/header_sync_frame_checker_assert.svh -----
// Assertion macros shared by the frame checker RTL.
`ifndef HEADER_SYNC_FRAME_CHECKER_ASSERT_SVH
`define HEADER_SYNC_FRAME_CHECKER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define HSFC_ASSERT_NOW(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define HSFC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hsfc_pkg.sv -----
// Shared types, constants and helpers for the header sync frame checker.
`timescale 1ns / 1ps

package hsfc_pkg;

    // Longest sync header the hunter matches.
    localparam int MAX_HEADER = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEADER_BYTES = 3'd0;
    localparam logic [2:0] REG_HEADER_LEN   = 3'd1;
    localparam logic [2:0] REG_FRAME_LEN    = 3'd2;
    localparam logic [2:0] REG_CHECK_ENABLE = 3'd3;
    localparam logic [2:0] REG_SUM_START    = 3'd4;
    localparam logic [2:0] REG_SUM_END      = 3'd5;
    localparam logic [2:0] REG_CHECK_INDEX  = 3'd6;

    // Live configuration.
    typedef struct packed {
        logic [31:0] header_bytes;
        logic [2:0]  header_len;
        logic [6:0]  frame_len;
        logic        check_enable;
        logic [5:0]  sum_start;
        logic [5:0]  sum_end;
        logic [5:0]  check_index;
    } cfg_t;

    // Completed frame handed from front to back.
    typedef struct packed {
        logic       bank;
        logic [6:0] fl;
    } cmd_t;

    // Frame buffer write from the front.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [5:0] idx;
        logic [7:0] data;
    } wr_t;

    // Bank handed back once its frame is fully emitted.
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    // Command queue status.
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    // Header byte k; bytes beyond the fourth match zero.
    function automatic logic [7:0] hdr_byte(input logic [31:0] hb, input logic [2:0] k);
        logic [31:0] sh;
        sh = hb >> {k[1:0], 3'b000};
        return k[2] ? 8'd0 : sh[7:0];
    endfunction

endpackage

// ----- sv/hsfc_queue.sv -----
// Two-entry command queue between the frame hunter and the checker/replayer.
`timescale 1ns / 1ps

module hsfc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hsfc_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output hsfc_pkg::cmd_t    pop_cmd,
    output hsfc_pkg::q_stat_t stat
);

    hsfc_pkg::cmd_t entry_reg [0:1];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = count_reg[1];

endmodule

// ----- sv/hsfc_front.sv -----
// Front end: hunt the sync header, steer bytes into a frame bank, post completed frames.
`timescale 1ns / 1ps

module hsfc_front #(
    parameter int MAX_FRAME = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  hsfc_pkg::cfg_t cfg,
    input  hsfc_pkg::rel_t rel,
    output hsfc_pkg::wr_t  wr,
    output logic           push,
    output hsfc_pkg::cmd_t push_cmd
);

    localparam logic [6:0] MAX_FL = 7'(MAX_FRAME);
    localparam logic [6:0] MAX_HL = 7'(hsfc_pkg::MAX_HEADER);

    logic       phase_reg;
    logic       phase_next;
    logic [6:0] fill_reg;
    logic [6:0] fill_next;
    logic       bank_reg;
    logic       bank_next;
    logic [1:0] busy_reg;
    logic [1:0] busy_next;

    logic [6:0] hl;
    logic [6:0] fl;
    logic [6:0] pos;
    logic       accept;
    logic       done;

    // Clamp header and frame length to their legal ranges
    always_comb
    begin
        hl = {4'd0, cfg.header_len};
        if (hl == 7'd0)
        begin
            hl = 7'd1;
        end
        if (hl > MAX_HL)
        begin
            hl = MAX_HL;
        end
        if (hl > MAX_FL)
        begin
            hl = MAX_FL;
        end
        fl = cfg.frame_len;
        if (fl == 7'd0)
        begin
            fl = 7'd1;
        end
        if (fl > MAX_FL)
        begin
            fl = MAX_FL;
        end
        if (fl < hl)
        begin
            fl = hl;
        end
    end

    // Hold off input while the current bank still belongs to the back end
    assign in_ready = !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;

    // Match header, store bytes, detect frame completion
    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        bank_next  = bank_reg;
        pos        = fill_reg;
        done       = 1'b0;
        wr.en      = 1'b0;
        wr.bank    = bank_reg;
        wr.idx     = fill_reg[5:0];
        wr.data    = data_byte;
        if (accept)
        begin
            if (!phase_reg && (fill_reg < hl))
            begin
                // Retry a mismatching byte as the first header byte
                if (data_byte != hsfc_pkg::hdr_byte(cfg.header_bytes, pos[2:0]))
                begin
                    pos = 7'd0;
                end
                if (data_byte == hsfc_pkg::hdr_byte(cfg.header_bytes, pos[2:0]))
                begin
                    wr.en  = 1'b1;
                    wr.idx = pos[5:0];
                    pos    = pos + 7'd1;
                    if (pos >= hl)
                    begin
                        phase_next = 1'b1;
                        if (pos >= fl)
                        begin
                            done = 1'b1;
                        end
                    end
                end
                fill_next = pos;
            end
            else
            begin
                phase_next = 1'b1;
                if (pos < MAX_FL)
                begin
                    wr.en  = 1'b1;
                    wr.idx = pos[5:0];
                    pos    = pos + 7'd1;
                end
                if (pos >= fl)
                begin
                    done = 1'b1;
                end
                fill_next = pos;
            end
            if (done)
            begin
                phase_next = 1'b0;
                fill_next  = 7'd0;
                bank_next  = ~bank_reg;
            end
        end
    end

    assign push          = done;
    assign push_cmd.bank = bank_reg;
    assign push_cmd.fl   = fl;

    // Track bank ownership
    always_comb
    begin
        busy_next = busy_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (done)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            fill_reg  <= 7'd0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ----- sv/hsfc_back.sv -----
// Back end: frame buffer, checksum sequencer, frame replay and output register.
`timescale 1ns / 1ps

module hsfc_back #(
    parameter int MAX_FRAME = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hsfc_pkg::cfg_t    cfg,
    input  hsfc_pkg::wr_t     wr,
    input  hsfc_pkg::q_stat_t q_stat,
    input  hsfc_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output hsfc_pkg::rel_t    rel,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        frame_byte,
    output logic [5:0]        byte_index,
    output logic              last_byte,
    output logic              frame_good,
    output logic [31:0]       good_count,
    output logic [31:0]       bad_count
);

    localparam int AW    = $clog2(MAX_FRAME);
    localparam int DEPTH = 2 * (1 << AW);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_SUM      = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_DECIDE   = 3'd4;
    localparam logic [2:0] ST_PLAY_RD  = 3'd5;
    localparam logic [2:0] ST_PLAY_OUT = 3'd6;
    localparam logic [2:0] ST_REJECT   = 3'd7;

    logic [7:0]  frame_mem [0:DEPTH-1];
    logic [7:0]  rd_data_reg;
    logic [AW:0] rd_addr;
    logic [5:0]  rd_idx;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic        bank_reg;
    logic        bank_next;
    logic [6:0]  fl_reg;
    logic [6:0]  fl_next;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  chk_reg;
    logic [7:0]  chk_next;
    logic        rdv_reg;
    logic        rdv_next;
    logic        rdm_reg;
    logic        rdm_next;
    logic        chk_pend_reg;
    logic        chk_pend_next;
    logic [31:0] good_reg;
    logic [31:0] good_next;
    logic [31:0] bad_reg;
    logic [31:0] bad_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [5:0]  out_idx_reg;
    logic        out_last_reg;
    logic        out_good_reg;
    logic [31:0] out_gcnt_reg;
    logic [31:0] out_bcnt_reg;

    logic        out_free;
    logic        load;
    logic [7:0]  ld_byte;
    logic [5:0]  ld_idx;
    logic        ld_last;
    logic        ld_good;

    // Pick the read index for the sequencer
    assign rd_idx  = (state_reg == ST_CHECK) ? cfg.check_index : idx_reg;
    assign rd_addr = {bank_reg, rd_idx[AW-1:0]};

    // Frame buffer: one write port from the front, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            frame_mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    assign out_free = !out_valid_reg || out_ready;

    // Sequence checksum, decision and replay
    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        fl_next       = fl_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        rdv_next      = 1'b0;
        rdm_next      = 1'b0;
        chk_pend_next = 1'b0;
        good_next     = good_reg;
        bad_next      = bad_reg;
        q_pop         = 1'b0;
        rel.en        = 1'b0;
        rel.bank      = bank_reg;
        load          = 1'b0;
        ld_byte       = rd_data_reg;
        ld_idx        = idx_reg;
        ld_last       = 1'b0;
        ld_good       = 1'b1;

        // Fold in read data; bytes past the frame count as zero
        if (rdv_reg)
        begin
            sum_next = sum_reg + (rdm_reg ? rd_data_reg : 8'd0);
        end
        if (chk_pend_reg)
        begin
            chk_next = rdm_reg ? rd_data_reg : 8'd0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    q_pop      = 1'b1;
                    bank_next  = q_cmd.bank;
                    fl_next    = q_cmd.fl;
                    sum_next   = 8'd0;
                    chk_next   = 8'd0;
                    state_next = cfg.check_enable ? ST_CHECK : ST_DECIDE;
                end
            end
            ST_CHECK:
            begin
                chk_pend_next = 1'b1;
                rdm_next      = ({1'b0, cfg.check_index} < fl_reg);
                idx_next      = cfg.sum_start;
                state_next    = (cfg.sum_start > cfg.sum_end) ? ST_DRAIN : ST_SUM;
            end
            ST_SUM:
            begin
                rdv_next = 1'b1;
                rdm_next = ({1'b0, idx_reg} < fl_reg);
                if (idx_reg == cfg.sum_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!cfg.check_enable || (sum_reg == chk_reg))
                begin
                    good_next  = good_reg + 32'd1;
                    idx_next   = 6'd0;
                    state_next = ST_PLAY_RD;
                end
                else
                begin
                    bad_next   = bad_reg + 32'd1;
                    state_next = ST_REJECT;
                end
            end
            ST_PLAY_RD:
            begin
                state_next = ST_PLAY_OUT;
            end
            ST_PLAY_OUT:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_last = (({1'b0, idx_reg} + 7'd1) == fl_reg);
                    if (ld_last)
                    begin
                        rel.en     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = ST_PLAY_RD;
                    end
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_byte    = 8'd0;
                    ld_idx     = 6'd0;
                    ld_last    = 1'b1;
                    ld_good    = 1'b0;
                    rel.en     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Fill or drain the output register
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rdv_reg       <= 1'b0;
            chk_pend_reg  <= 1'b0;
            good_reg      <= 32'd0;
            bad_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rdv_reg       <= rdv_next;
            chk_pend_reg  <= chk_pend_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        fl_reg   <= fl_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        chk_reg  <= chk_next;
        rdm_reg  <= rdm_next;
        if (load)
        begin
            out_byte_reg <= ld_byte;
            out_idx_reg  <= ld_idx;
            out_last_reg <= ld_last;
            out_good_reg <= ld_good;
            out_gcnt_reg <= good_reg;
            out_bcnt_reg <= bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign last_byte  = out_last_reg;
    assign frame_good = out_good_reg;
    assign good_count = out_gcnt_reg;
    assign bad_count  = out_bcnt_reg;

endmodule

// ----- sv/header_sync_frame_checker.sv -----
// Top level: configuration registers, front/back split and the command queue between them.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  cfg     | cfg_we                  | cfg_index, cfg_data
//  in      | in_valid / in_ready     | data_byte
//  out     | out_valid / out_ready   | frame_byte, byte_index, last_byte, frame_good,
//          |                         | good_count, bad_count
//
// The front takes one item per cycle while its frame bank is free; two banks let it fill
// one frame while the back works on the other, and in_ready drops when both are held.
// Per frame the back pops a command; when checking it reads the check byte, sums the
// bytes sum_start to sum_end (none for an empty sum range) and drains the read port;
// then it decides and replays each byte (one read of the frame buffer port per byte).
// A reject takes one result slot. A stalled output register holds the back in replay or reject.
// Reset is asynchronous; the frame buffer needs no clearing pass.
`timescale 1ns / 1ps

module header_sync_frame_checker #(
    parameter int MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic [5:0]  byte_index,
    output logic        last_byte,
    output logic        frame_good,
    output logic [31:0] good_count,
    output logic [31:0] bad_count
);

    hsfc_pkg::cfg_t    cfg_reg;
    hsfc_pkg::cfg_t    cfg_next;
    hsfc_pkg::wr_t     wr;
    hsfc_pkg::rel_t    rel;
    hsfc_pkg::cmd_t    push_cmd;
    hsfc_pkg::cmd_t    q_cmd;
    hsfc_pkg::q_stat_t q_stat;
    logic              push;
    logic              q_pop;

    // Decode configuration writes; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hsfc_pkg::REG_HEADER_BYTES: cfg_next.header_bytes = cfg_data;
                hsfc_pkg::REG_HEADER_LEN:   cfg_next.header_len   = cfg_data[2:0];
                hsfc_pkg::REG_FRAME_LEN:    cfg_next.frame_len    = cfg_data[6:0];
                hsfc_pkg::REG_CHECK_ENABLE: cfg_next.check_enable = cfg_data[0];
                hsfc_pkg::REG_SUM_START:    cfg_next.sum_start    = cfg_data[5:0];
                hsfc_pkg::REG_SUM_END:      cfg_next.sum_end      = cfg_data[5:0];
                hsfc_pkg::REG_CHECK_INDEX:  cfg_next.check_index  = cfg_data[5:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes <= 32'd0;
            cfg_reg.header_len   <= 3'd2;
            cfg_reg.frame_len    <= 7'd8;
            cfg_reg.check_enable <= 1'b0;
            cfg_reg.sum_start    <= 6'd0;
            cfg_reg.sum_end      <= 6'd0;
            cfg_reg.check_index  <= 6'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hsfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .rel       (rel),
        .wr        (wr),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    hsfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .stat     (q_stat)
    );

    hsfc_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .wr         (wr),
        .q_stat     (q_stat),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .rel        (rel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last_byte  (last_byte),
        .frame_good (frame_good),
        .good_count (good_count),
        .bad_count  (bad_count)
    );

`include "header_sync_frame_checker_assert.svh"

    `HSFC_ASSERT_NOW(a_wr_on_accept, wr.en, in_valid && in_ready, "buffer write without accepted item")
    `HSFC_ASSERT_NOW(a_push_room, push, !q_stat.full, "frame posted to a full queue")
    `HSFC_ASSERT_NOW(a_reject_shape, out_valid && !frame_good, last_byte && frame_byte == 8'd0 && byte_index == 6'd0, "malformed reject result")
    `HSFC_ASSERT_NEXT(a_release_last, rel.en, out_valid && last_byte, "bank released before last result")

endmodule
